// ===== design/spelling_nearest_name_search_assert.svh =====
// ---------------------------------------------------------------------------
// assertion helpers for the nearest name search
// concurrent checks clocked on clock and disabled during reset
// ---------------------------------------------------------------------------
`ifndef SPELLING_NEAREST_NAME_SEARCH_ASSERT_SVH
`define SPELLING_NEAREST_NAME_SEARCH_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SNNS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SNNS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/snns_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// snns_pkg
// shared types and codes of the nearest name search
// ---------------------------------------------------------------------------
package snns_pkg;

   // name packing
   localparam int CHAR_W     = 8;
   localparam int WORD_CHARS = 7;
   localparam int WORD_W     = CHAR_W * WORD_CHARS;

   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [WORD_W-1:0] word_type;
   typedef logic [1:0]        dist_type;

   // distance codes
   localparam dist_type DIST_EXACT = 2'd0;
   localparam dist_type DIST_SWAP  = 2'd1;
   localparam dist_type DIST_EDIT  = 2'd2;
   localparam dist_type DIST_FAR   = 2'd3;

   // register map
   localparam int CSR_ADDR_W = 1;
   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;
   localparam csr_addr_type CSR_GUESS_LOW  = 1'b0;
   localparam csr_addr_type CSR_GUESS_HIGH = 1'b1;

endpackage

// ===== design/snns_req_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// snns_req_if
// directory entry channel: one entry name per beat
// ---------------------------------------------------------------------------
interface snns_req_if import snns_pkg::*;;
   logic     valid;
   logic     ready;
   word_type candidate_chars_low;
   word_type candidate_chars_high;
   logic     entry_in_use;
   logic     last_entry;

   modport source (
      output valid, candidate_chars_low, candidate_chars_high, entry_in_use, last_entry,
      input  ready
   );
   modport sink (
      input  valid, candidate_chars_low, candidate_chars_high, entry_in_use, last_entry,
      output ready
   );
endinterface

// ===== design/snns_rsp_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// snns_rsp_if
// result channel: one search status per beat
// ---------------------------------------------------------------------------
interface snns_rsp_if import snns_pkg::*;;
   logic     valid;
   logic     ready;
   dist_type entry_distance;
   dist_type best_distance;
   logic     found;
   word_type best_name_low;
   word_type best_name_high;
   logic     search_done;

   modport source (
      output valid, entry_distance, best_distance, found, best_name_low, best_name_high,
             search_done,
      input  ready
   );
   modport sink (
      input  valid, entry_distance, best_distance, found, best_name_low, best_name_high,
             search_done,
      output ready
   );
endinterface

// ===== design/snns_csr_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// snns_csr_if
// register write channel: address and data per beat
// ---------------------------------------------------------------------------
interface snns_csr_if import snns_pkg::*;;
   logic         valid;
   logic         ready;
   csr_addr_type addr;
   word_type     data;

   modport source (
      output valid, addr, data,
      input  ready
   );
   modport sink (
      input  valid, addr, data,
      output ready
   );
endinterface

// ===== design/spelling_nearest_name_search.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spelling_nearest_name_search
// Compares each directory entry name against a guessed name held in two
// registers and keeps the nearest one (exact, one adjacent swap, or one
// wrong, added or dropped character). One entry is taken every clock cycle
// while the result side is not back-pressured, and its result is registered: an input register
// holds the entry, the character compare and best-so-far update run in one
// combinational step, and a result register holds the answer. Throughput is
// set by that single compare step; the result register lets a new entry in
// while an earlier result still waits. The entry flagged last reports the
// best name and restarts the search. Write the guess only while idle.
// ---------------------------------------------------------------------------
`include "spelling_nearest_name_search_assert.svh"

module spelling_nearest_name_search
   import snns_pkg::*;
#(
   parameter int NAME_CHARS = 14
) (
   input  logic           clock,
   input  logic           reset,
   snns_req_if.sink       req_port,
   snns_rsp_if.source     rsp_port,
   snns_csr_if.sink       csr_port
);

   // guess registers
   word_type guess_low_ff;
   word_type guess_high_ff;

   // input stage
   logic     s1_valid_ff;
   word_type s1_low_ff;
   word_type s1_high_ff;
   logic     s1_in_use_ff;
   logic     s1_last_ff;

   // search state
   dist_type best_score_ff;
   dist_type best_score_in;
   word_type best_low_ff;
   word_type best_low_in;
   word_type best_high_ff;
   word_type best_high_in;
   logic     exact_seen_ff;
   logic     exact_seen_in;

   // result stage
   logic     rsp_valid_ff;
   dist_type rsp_entry_dist_ff;
   dist_type rsp_best_dist_ff;
   logic     rsp_found_ff;
   word_type rsp_low_ff;
   word_type rsp_high_ff;
   logic     rsp_done_ff;

   // handshake
   logic rsp_free;
   logic s1_advance;
   logic req_fire;

   // character views, one spare zero slot past the end
   char_type cand_raw  [NAME_CHARS];
   char_type guess_raw [NAME_CHARS];
   char_type cand_chr  [NAME_CHARS+1];
   char_type guess_chr [NAME_CHARS+1];
   logic [NAME_CHARS-1:0] cand_nz;
   logic [NAME_CHARS-1:0] guess_nz;
   word_type cand_norm_low;
   word_type cand_norm_high;

   // compare vectors
   logic [NAME_CHARS-1:0] eq_same;
   logic [NAME_CHARS-1:0] eq_drop;
   logic [NAME_CHARS-1:0] eq_add;
   logic [NAME_CHARS+1:0] suf_same;
   logic [NAME_CHARS-1:0] suf_drop;
   logic [NAME_CHARS-1:0] suf_add;
   logic [NAME_CHARS-1:0] first_mis;
   logic [NAME_CHARS-1:0] swap_hit;
   logic [NAME_CHARS-1:0] edit_hit;
   dist_type name_dist;
   dist_type entry_dist;
   logic     take_entry;

   // ---------------------------------------------------------------------
   // register writes
   // ---------------------------------------------------------------------
   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         guess_low_ff  <= '0;
         guess_high_ff <= '0;
      end else if (csr_port.valid) begin
         case (csr_port.addr)
            CSR_GUESS_LOW:  guess_low_ff  <= csr_port.data;
            CSR_GUESS_HIGH: guess_high_ff <= csr_port.data;
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // flow control
   // ---------------------------------------------------------------------
   assign rsp_free       = !rsp_valid_ff || rsp_port.ready;
   assign s1_advance     = s1_valid_ff && rsp_free;
   assign req_port.ready = !s1_valid_ff || rsp_free;
   assign req_fire       = req_port.valid && req_port.ready;

   // ---------------------------------------------------------------------
   // unpack and cut names at the first zero character
   // ---------------------------------------------------------------------
   for (genvar i = 0; i < NAME_CHARS; i++) begin : g_unpack
      if (i < WORD_CHARS) begin : g_low
         assign cand_raw[i]  = s1_low_ff[CHAR_W*i +: CHAR_W];
         assign guess_raw[i] = guess_low_ff[CHAR_W*i +: CHAR_W];
      end else begin : g_high
         assign cand_raw[i]  = s1_high_ff[CHAR_W*(i-WORD_CHARS) +: CHAR_W];
         assign guess_raw[i] = guess_high_ff[CHAR_W*(i-WORD_CHARS) +: CHAR_W];
      end
      assign cand_nz[i]   = (cand_raw[i] != '0);
      assign guess_nz[i]  = (guess_raw[i] != '0);
      assign cand_chr[i]  = (&cand_nz[i:0])  ? cand_raw[i]  : '0;
      assign guess_chr[i] = (&guess_nz[i:0]) ? guess_raw[i] : '0;
   end
   assign cand_chr[NAME_CHARS]  = '0;
   assign guess_chr[NAME_CHARS] = '0;

   // normalised candidate, unused slots zero
   for (genvar i = 0; i < 2*WORD_CHARS; i++) begin : g_pack
      if (i < WORD_CHARS) begin : g_low
         if (i < NAME_CHARS) begin : g_used
            assign cand_norm_low[CHAR_W*i +: CHAR_W] = cand_chr[i];
         end else begin : g_spare
            assign cand_norm_low[CHAR_W*i +: CHAR_W] = '0;
         end
      end else begin : g_high
         if (i < NAME_CHARS) begin : g_used
            assign cand_norm_high[CHAR_W*(i-WORD_CHARS) +: CHAR_W] = cand_chr[i];
         end else begin : g_spare
            assign cand_norm_high[CHAR_W*(i-WORD_CHARS) +: CHAR_W] = '0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // position compares: aligned, candidate one ahead, guess one ahead
   // ---------------------------------------------------------------------
   for (genvar j = 0; j < NAME_CHARS; j++) begin : g_cmp
      assign eq_same[j]  = (cand_chr[j]   == guess_chr[j]);
      assign eq_drop[j]  = (cand_chr[j+1] == guess_chr[j]);
      assign eq_add[j]   = (cand_chr[j]   == guess_chr[j+1]);
      assign suf_same[j] = &eq_same[NAME_CHARS-1:j];
      assign suf_drop[j] = &eq_drop[NAME_CHARS-1:j];
      assign suf_add[j]  = &eq_add[NAME_CHARS-1:j];
      if (j == 0) begin : g_first
         assign first_mis[j] = !eq_same[j];
      end else begin : g_rest
         assign first_mis[j] = !eq_same[j] && (&eq_same[j-1:0]);
      end
   end
   assign suf_same[NAME_CHARS]   = 1'b1;
   assign suf_same[NAME_CHARS+1] = 1'b1;

   // ---------------------------------------------------------------------
   // repair tests at each possible first mismatch
   // ---------------------------------------------------------------------
   for (genvar j = 0; j < NAME_CHARS; j++) begin : g_fix
      logic cand_live;
      logic guess_live;
      assign cand_live  = (cand_chr[j]  != '0);
      assign guess_live = (guess_chr[j] != '0);
      // adjacent pair swapped, rest identical
      assign swap_hit[j] = cand_live && guess_live &&
                           (cand_chr[j+1] != '0) && (guess_chr[j+1] != '0) &&
                           (cand_chr[j] == guess_chr[j+1]) &&
                           (guess_chr[j] == cand_chr[j+1]) && suf_same[j+2];
      // wrong character, extra character in candidate, or missing character
      assign edit_hit[j] = (cand_live && guess_live && suf_same[j+1]) ||
                           (cand_live && suf_drop[j]) ||
                           (guess_live && suf_add[j]);
   end

   always_comb begin
      if (&eq_same) begin
         name_dist = DIST_EXACT;
      end else if (|(first_mis & swap_hit)) begin
         name_dist = DIST_SWAP;
      end else if (|(first_mis & edit_hit)) begin
         name_dist = DIST_EDIT;
      end else begin
         name_dist = DIST_FAR;
      end
   end

   // ---------------------------------------------------------------------
   // running best update
   // ---------------------------------------------------------------------
   always_comb begin
      entry_dist    = s1_in_use_ff ? name_dist : DIST_FAR;
      take_entry    = s1_in_use_ff && !exact_seen_ff && (entry_dist != DIST_FAR) &&
                      (entry_dist <= best_score_ff);
      best_score_in = take_entry ? entry_dist     : best_score_ff;
      best_low_in   = take_entry ? cand_norm_low  : best_low_ff;
      best_high_in  = take_entry ? cand_norm_high : best_high_ff;
      exact_seen_in = exact_seen_ff || (take_entry && (entry_dist == DIST_EXACT));
   end

   // ---------------------------------------------------------------------
   // control and state registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         best_score_ff <= DIST_FAR;
         best_low_ff   <= '0;
         best_high_ff  <= '0;
         exact_seen_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // last entry of the scan restarts the search
         if (s1_advance) begin
            if (s1_last_ff) begin
               best_score_ff <= DIST_FAR;
               best_low_ff   <= '0;
               best_high_ff  <= '0;
               exact_seen_ff <= 1'b0;
            end else begin
               best_score_ff <= best_score_in;
               best_low_ff   <= best_low_in;
               best_high_ff  <= best_high_in;
               exact_seen_ff <= exact_seen_in;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // payload registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_low_ff    <= req_port.candidate_chars_low;
         s1_high_ff   <= req_port.candidate_chars_high;
         s1_in_use_ff <= req_port.entry_in_use;
         s1_last_ff   <= req_port.last_entry;
      end
      if (s1_advance) begin
         rsp_entry_dist_ff <= entry_dist;
         rsp_best_dist_ff  <= best_score_in;
         rsp_found_ff      <= (best_score_in != DIST_FAR);
         rsp_low_ff        <= best_low_in;
         rsp_high_ff       <= best_high_in;
         rsp_done_ff       <= s1_last_ff;
      end
   end

   // result beat
   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.entry_distance = rsp_entry_dist_ff;
   assign rsp_port.best_distance  = rsp_best_dist_ff;
   assign rsp_port.found          = rsp_found_ff;
   assign rsp_port.best_name_low  = rsp_low_ff;
   assign rsp_port.best_name_high = rsp_high_ff;
   assign rsp_port.search_done    = rsp_done_ff;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   `SNNS_ASSERT_NOW(a_exact_frozen, exact_seen_ff, best_score_ff == DIST_EXACT, "exact match kept with nonzero best score")
   `SNNS_ASSERT_NOW(a_empty_best, best_score_ff == DIST_FAR, (best_low_ff == '0) && (best_high_ff == '0), "best name held with no match")
   `SNNS_ASSERT_NEXT(a_best_monotonic, s1_advance && !s1_last_ff, best_score_ff <= $past(best_score_ff), "best score grew within a search")
   `SNNS_ASSERT_NEXT(a_clear_on_last, s1_advance && s1_last_ff, (best_score_ff == DIST_FAR) && !exact_seen_ff, "search not cleared after last entry")

endmodule

// ===== tb/sv/snns_nearest_name_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// snns_nearest_name_checker
// Watches the entry, result and register channels of the nearest name
// search. Keeps its own guess and running best, predicts the status for
// every accepted entry beat and compares each result beat field by field.
// ---------------------------------------------------------------------------
module snns_nearest_name_checker
   import snns_pkg::*;
#(
   parameter int NAME_CHARS = 14
) (
   input  logic clock,
   input  logic reset,
   snns_req_if  req_bus,
   snns_rsp_if  rsp_bus,
   snns_csr_if  csr_bus,
   output int   mismatch_count,
   output int   pending_count,
   output int   found_count
);

   localparam int SLOT_COUNT = 2 * WORD_CHARS;
   // three spare zero slots past the name so the tail compares never overrun
   localparam int BUF_LEN    = NAME_CHARS + 3;

   typedef char_type name_buf_type [0:BUF_LEN-1];
   typedef logic [2*WORD_W-1:0] name_pair_type;

   typedef struct packed {
      dist_type entry_distance;
      dist_type best_distance;
      logic     found;
      word_type best_name_low;
      word_type best_name_high;
      logic     search_done;
   } search_status_type;

   // guess registers and running best
   word_type          guess_low;
   word_type          guess_high;
   dist_type          best_score;
   word_type          best_low;
   word_type          best_high;
   logic              exact_seen;
   search_status_type expected_status_q [$];

   // unpack to a terminated buffer, blanking slots after the first zero
   function automatic name_buf_type trim_name(word_type lo, word_type hi);
      name_buf_type nb;
      logic         ended;
      char_type     c;
      int           i;
      ended = 1'b0;
      for (i = 0; i < BUF_LEN; i++) nb[i] = '0;
      for (i = 0; i < NAME_CHARS && i < SLOT_COUNT; i++) begin
         if (i < WORD_CHARS) c = lo[i*CHAR_W +: CHAR_W];
         else c = hi[(i-WORD_CHARS)*CHAR_W +: CHAR_W];
         if (c == '0) ended = 1'b1;
         nb[i] = ended ? char_type'(0) : c;
      end
      return nb;
   endfunction

   function automatic name_pair_type pack_name(name_buf_type nb);
      name_pair_type w;
      int            i;
      w = '0;
      for (i = 0; i < NAME_CHARS && i < SLOT_COUNT; i++) w[i*CHAR_W +: CHAR_W] = nb[i];
      return w;
   endfunction

   // remaining strings equal from the given offsets
   function automatic bit tails_match(name_buf_type a, int ia, name_buf_type b, int ib);
      while (ia < BUF_LEN && ib < BUF_LEN) begin
         if (a[ia] != b[ib]) return 1'b0;
         if (b[ib] == '0) return 1'b1;
         ia++;
         ib++;
      end
      return 1'b1;
   endfunction

   // rough spelling distance of entry s from guess t
   function automatic dist_type name_distance(name_buf_type s, name_buf_type t);
      int k;
      k = 0;
      while (k < NAME_CHARS && s[k] == t[k]) begin
         if (t[k] == '0) return DIST_EXACT;
         k++;
      end
      if (k >= NAME_CHARS) return DIST_EXACT;
      if (s[k] != '0) begin
         if (t[k] != '0) begin
            if (s[k+1] != '0 && t[k+1] != '0 && s[k] == t[k+1] && t[k] == s[k+1] &&
                tails_match(s, k + 2, t, k + 2)) return DIST_SWAP;
            if (tails_match(s, k + 1, t, k + 1)) return DIST_EDIT;
         end
         if (tails_match(s, k + 1, t, k)) return DIST_EDIT;
      end
      if (t[k] != '0 && tails_match(s, k, t, k + 1)) return DIST_EDIT;
      return DIST_FAR;
   endfunction

   task automatic clear_search();
      best_score = DIST_FAR;
      best_low   = '0;
      best_high  = '0;
      exact_seen = 1'b0;
   endtask

   // running best update for one entry beat
   task automatic predict_entry();
      name_buf_type      cand;
      name_buf_type      guess;
      dist_type          entry_score;
      name_pair_type     norm;
      search_status_type st;
      entry_score = DIST_FAR;
      if (req_bus.entry_in_use) begin
         cand        = trim_name(req_bus.candidate_chars_low, req_bus.candidate_chars_high);
         guess       = trim_name(guess_low, guess_high);
         entry_score = name_distance(cand, guess);
         if (!exact_seen && entry_score != DIST_FAR && entry_score <= best_score) begin
            norm       = pack_name(cand);
            best_low   = norm[WORD_W-1:0];
            best_high  = norm[2*WORD_W-1:WORD_W];
            best_score = entry_score;
            if (entry_score == DIST_EXACT) exact_seen = 1'b1;
         end
      end
      st.entry_distance = entry_score;
      st.best_distance  = best_score;
      st.found          = (best_score != DIST_FAR);
      st.best_name_low  = best_low;
      st.best_name_high = best_high;
      st.search_done    = req_bus.last_entry;
      expected_status_q.push_back(st);
      if (req_bus.last_entry) clear_search();
   endtask

   task automatic check_field(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", field, want, got);
         mismatch_count++;
      end
   endtask

   // compare the oldest expectation against a result beat
   task automatic check_status();
      search_status_type st;
      if (expected_status_q.size() == 0) begin
         $error("result beat with no entry waiting for it");
         mismatch_count++;
      end else begin
         st = expected_status_q.pop_front();
         if (st.found) found_count++;
         check_field("entry_distance", st.entry_distance, rsp_bus.entry_distance);
         check_field("best_distance", st.best_distance, rsp_bus.best_distance);
         check_field("found", st.found, rsp_bus.found);
         check_field("best_name_low", st.best_name_low, rsp_bus.best_name_low);
         check_field("best_name_high", st.best_name_high, rsp_bus.best_name_high);
         check_field("search_done", st.search_done, rsp_bus.search_done);
      end
   endtask

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      found_count    = 0;
   end

   // channel monitor: results first so a beat never meets its own prediction
   always @(posedge clock) begin
      if (reset) begin
         guess_low  = '0;
         guess_high = '0;
         clear_search();
         expected_status_q.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) check_status();
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.addr)
               CSR_GUESS_LOW:  guess_low = csr_bus.data;
               CSR_GUESS_HIGH: guess_high = csr_bus.data;
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) predict_entry();
      end
      pending_count = expected_status_q.size();
   end

endmodule

// ===== tb/sv/tb_spelling_nearest_name_search.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_spelling_nearest_name_search
// Drives directory scans into the nearest name search: a directed set of
// distance cases under a few fixed guesses, then random scans built by
// mutating a random guess, mixed with raw noise beats. Both channels idle
// at random; the checker beside the block does the prediction.
// ---------------------------------------------------------------------------
module tb_spelling_nearest_name_search
   import snns_pkg::*;
;

   localparam int NAME_CHARS     = 14;
   localparam int SLOT_COUNT     = 2 * WORD_CHARS;
   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int RANDOM_ENTRIES = 1300;
   localparam int GUESS_PHASES   = 8;

   typedef logic [2*WORD_W-1:0] name_pair_type;
   typedef char_type char_q_type [$];

   logic clock;
   logic reset;
   logic steady_send;
   int   cycle_count;
   int   entries_sent;
   int   scans_closed;
   int   guess_writes;
   int   mismatch_count;
   int   pending_count;
   int   found_count;

   snns_req_if req_bus ();
   snns_rsp_if rsp_bus ();
   snns_csr_if csr_bus ();

   spelling_nearest_name_search #(
      .NAME_CHARS (NAME_CHARS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   snns_nearest_name_checker #(
      .NAME_CHARS (NAME_CHARS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_bus        (csr_bus),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .found_count    (found_count)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("spelling_nearest_name_search: mismatch");
         $finish;
      end
   end

   // idle length: mostly short, now and then long
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(99);
      if (roll < 45) return 0;
      if (roll < 85) return $urandom_range(3, 1);
      if (roll < 96) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // result side back-pressure
   initial begin
      int run;
      int gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         run = ($urandom_range(9) == 0) ? $urandom_range(200, 40) : $urandom_range(8, 1);
         repeat (run) begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
         gap = gap_length();
         repeat (gap) begin
            rsp_bus.ready <= 1'b0;
            @(posedge clock);
         end
      end
   end

   function automatic name_pair_type text_name(string s);
      name_pair_type w;
      int            i;
      w = '0;
      for (i = 0; i < s.len() && i < SLOT_COUNT; i++) w[i*CHAR_W +: CHAR_W] = s[i];
      return w;
   endfunction

   // small alphabet most of the time so swaps and ties turn up
   function automatic char_type any_char();
      if ($urandom_range(3) == 0) return char_type'($urandom_range(255, 1));
      return char_type'(8'h61 + $urandom_range(3));
   endfunction

   function automatic char_q_type random_chars(int len);
      char_q_type q;
      int         i;
      for (i = 0; i < len; i++) q.push_back(any_char());
      return q;
   endfunction

   // pack with a zero terminator, optionally with rubbish past it
   function automatic name_pair_type pack_chars(char_q_type q, bit junk);
      name_pair_type w;
      int            i;
      w = '0;
      for (i = 0; i < SLOT_COUNT; i++) begin
         if (i < q.size()) w[i*CHAR_W +: CHAR_W] = q[i];
         else if (junk && i > q.size()) w[i*CHAR_W +: CHAR_W] = char_type'($urandom_range(255));
      end
      return w;
   endfunction

   // entry name close to the guess: exact, swap, substitution, insertion,
   // deletion, two edits or unrelated
   function automatic char_q_type near_name(char_q_type g);
      char_q_type c;
      char_type   t;
      int         pos;
      c = g;
      case ($urandom_range(9))
         0, 1: ;
         2: begin
            if (c.size() >= 2) begin
               pos      = $urandom_range(c.size() - 2);
               t        = c[pos];
               c[pos]   = c[pos+1];
               c[pos+1] = t;
            end
         end
         3: begin
            if (c.size() > 0) c[$urandom_range(c.size() - 1)] = any_char();
         end
         4: c.insert($urandom_range(c.size()), any_char());
         5: begin
            if (c.size() > 0) c.delete($urandom_range(c.size() - 1));
         end
         6, 7: c = near_name(near_name(g));
         default: c = random_chars($urandom_range(SLOT_COUNT));
      endcase
      return c;
   endfunction

   // one entry beat; valid stays high on return
   task automatic send_entry(name_pair_type name, logic in_use, logic last);
      int gap;
      gap = steady_send ? 0 : gap_length();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid                <= 1'b1;
      req_bus.candidate_chars_low  <= name[WORD_W-1:0];
      req_bus.candidate_chars_high <= name[2*WORD_W-1:WORD_W];
      req_bus.entry_in_use         <= in_use;
      req_bus.last_entry           <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      entries_sent++;
      if (last) scans_closed++;
   endtask

   task automatic write_reg(csr_addr_type addr, word_type data);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= addr;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
      guess_writes++;
   endtask

   task automatic write_guess(name_pair_type g);
      write_reg(CSR_GUESS_LOW, g[WORD_W-1:0]);
      write_reg(CSR_GUESS_HIGH, g[2*WORD_W-1:WORD_W]);
   endtask

   // hold entries back until every result is in, then let the pipe settle
   task automatic wait_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // stimulus and verdict
   initial begin
      char_q_type    guess_q;
      name_pair_type name;
      int            phase;
      int            phase_sent;
      int            scan_len;
      int            roll;
      int            glen;
      int            j;
      entries_sent = 0;
      scans_closed = 0;
      guess_writes = 0;
      steady_send  = 1'b0;
      reset                        <= 1'b1;
      req_bus.valid                <= 1'b0;
      req_bus.candidate_chars_low  <= '0;
      req_bus.candidate_chars_high <= '0;
      req_bus.entry_in_use         <= 1'b0;
      req_bus.last_entry           <= 1'b0;
      csr_bus.valid                <= 1'b0;
      csr_bus.addr                 <= CSR_GUESS_LOW;
      csr_bus.data                 <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // short guess with rubbish in the upper register past the terminator
      write_guess(text_name("kernel") | {{WORD_W{1'b1}}, {WORD_W{1'b0}}});
      send_entry(text_name("kernel"), 1'b0, 1'b0);
      send_entry(text_name("xyz"), 1'b1, 1'b0);
      send_entry(text_name("kernal"), 1'b1, 1'b0);
      send_entry(text_name("kernels"), 1'b1, 1'b0);
      send_entry(text_name("kernl"), 1'b1, 1'b0);
      send_entry(text_name("kenrel"), 1'b1, 1'b0);
      send_entry(text_name("kerne"), 1'b1, 1'b0);
      send_entry(text_name("kernel") | (name_pair_type'(8'hC3) << (8 * CHAR_W)), 1'b1, 1'b0);
      send_entry(text_name("ekrnel"), 1'b1, 1'b0);
      send_entry(text_name("kernel"), 1'b1, 1'b1);
      send_entry(text_name("kernel"), 1'b0, 1'b1);
      wait_results();

      // full length guess of all ones
      write_guess('1);
      send_entry(~(name_pair_type'(1) << ((SLOT_COUNT - 1) * CHAR_W)), 1'b1, 1'b0);
      send_entry(~(name_pair_type'(8'hFF) << ((SLOT_COUNT - 1) * CHAR_W)), 1'b1, 1'b0);
      send_entry('0, 1'b1, 1'b0);
      send_entry('1, 1'b1, 1'b1);
      wait_results();

      // empty guess
      write_guess('0);
      send_entry(text_name("a"), 1'b1, 1'b0);
      send_entry(text_name("ab"), 1'b1, 1'b0);
      send_entry(~name_pair_type'(8'hFF), 1'b1, 1'b1);
      wait_results();

      // swaps at both ends of a full length name
      write_guess(text_name("abcdefghijklmn"));
      send_entry(text_name("abcdefghijklnm"), 1'b1, 1'b0);
      send_entry(text_name("bacdefghijklmn"), 1'b1, 1'b0);
      send_entry(text_name("abcdefghijklm"), 1'b1, 1'b0);
      send_entry(text_name("abcdefghijklmn"), 1'b1, 1'b1);
      wait_results();

      // random scans, one guess per phase
      for (phase = 0; phase < GUESS_PHASES; phase++) begin
         roll = $urandom_range(9);
         if (phase == 0 || roll < 3) glen = SLOT_COUNT;
         else if (roll == 3) glen = 0;
         else if (roll == 4) glen = 1;
         else glen = $urandom_range(SLOT_COUNT - 1, 2);
         guess_q = random_chars(glen);
         write_guess(pack_chars(guess_q, 1'($urandom_range(1))));
         steady_send = (phase % 3 == 1);
         phase_sent  = 0;
         while (phase_sent < RANDOM_ENTRIES / GUESS_PHASES) begin
            scan_len = $urandom_range(10, 1);
            for (j = 0; j < scan_len; j++) begin
               if ($urandom_range(9) == 0) begin
                  // raw noise beat
                  name[31:0]   = $urandom;
                  name[63:32]  = $urandom;
                  name[95:64]  = $urandom;
                  name[111:96] = 16'($urandom_range(16'hFFFF));
                  send_entry(name, 1'($urandom_range(1)), 1'($urandom_range(1)));
               end else begin
                  send_entry(pack_chars(near_name(guess_q), $urandom_range(3) == 0),
                             $urandom_range(7) != 0, j == scan_len - 1);
               end
               phase_sent++;
            end
         end
         wait_results();
      end

      repeat (8) @(posedge clock);
      $display("%0d entries in %0d scans, %0d guess register writes",
               entries_sent, scans_closed, guess_writes);
      $display("%0d results reported a near name, %0d cycles", found_count, cycle_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("spelling_nearest_name_search: match");
      end else begin
         $display("spelling_nearest_name_search: mismatch");
      end
      $finish;
   end

endmodule

// ===== spelling_nearest_name_search.f =====
+incdir+design
design/snns_pkg.sv
design/snns_req_if.sv
design/snns_rsp_if.sv
design/snns_csr_if.sv
design/spelling_nearest_name_search.sv
tb/sv/snns_nearest_name_checker.sv
tb/sv/tb_spelling_nearest_name_search.sv
